// File: sv/mlc_pkg.sv
`timescale 1ns / 1ps
// Package for the lag correlator: widths, memory geometry and shared types.
// No dependencies.
package mlc_pkg;
  localparam int PARTICLE_COUNT = 256;
  localparam int LAG_DEPTH      = 32;
  localparam int SPECIES_COUNT  = 8;
  localparam int COORD_BITS     = 24;
  localparam int PART_W  = 8;
  localparam int SPEC_W  = 3;
  localparam int LAG_W   = 5;
  localparam int CLEN_W  = 6;
  localparam int FILL_W  = 6;
  localparam int TICK_W  = 32;
  localparam int ACC_W   = 64;
  localparam int DIFF_W  = COORD_BITS + 1;
  localparam int SQ_W    = 2 * COORD_BITS;
  localparam int DSUM_W  = SQ_W + 2;
  localparam logic [CLEN_W-1:0] CORR_LENGTH_RESET = CLEN_W'(20);
  localparam logic [FILL_W-1:0] FILL_MAX = '1;
  localparam logic MODE_SAMPLE = 1'b0;
  localparam logic MODE_READ   = 1'b1;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    logic signed [COORD_BITS-1:0] z;
  } pos_t;

  typedef struct packed {
    logic                      mode;
    logic [PART_W-1:0]         particle_index;
    logic [SPEC_W-1:0]         species_index;
    logic signed [COORD_BITS-1:0] pos_x;
    logic signed [COORD_BITS-1:0] pos_y;
    logic signed [COORD_BITS-1:0] pos_z;
    logic [LAG_W-1:0]          read_lag;
    logic                      last_of_tick;
  } in_item_t;

  typedef struct packed {
    logic [ACC_W-1:0]  sum_value;
    logic [TICK_W-1:0] ticks_taken;
    logic              history_ready;
  } out_item_t;
endpackage

// File: sv/mlc_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for items and the configuration write.
// Depends on mlc_pkg.
interface mlc_in_if import mlc_pkg::*; ();
  logic valid;
  logic ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface mlc_out_if import mlc_pkg::*; ();
  logic valid;
  logic ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface mlc_cfg_if import mlc_pkg::*; ();
  logic valid;
  logic ready;
  logic [CLEN_W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: sv/msd_lag_correlator.sv
`timescale 1ns / 1ps
// Top level of the mean squared displacement lag correlator.
// Depends on mlc_pkg, mlc_if and mlc_dist.
//
// One item at a time. A sample that does not accumulate goes from idle to the
// drain and output states; a read item passes the read state first. An
// accumulating sample walks lags 1..corr_length-1, one lag per cycle, through
// the history memory read, the squared displacement pipe and the accumulator
// read-modify-write, and then drains. After reset a clearing pass over all 256
// entries zeroes the accumulator memory before the first item is taken.
// Position history is undefined until written.
module msd_lag_correlator import mlc_pkg::*; (
  input logic clk,
  input logic rst,
  mlc_in_if.sink   in_ch,
  mlc_out_if.source out_ch,
  mlc_cfg_if.sink  cfg
);
  localparam int HIST_AW = PART_W + LAG_W;
  localparam int ACC_AW  = SPEC_W + LAG_W;

  typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_READ, S_WALK, S_DRAIN, S_OUT} state_t;
  state_t state;

  pos_t            hist_mem [2**HIST_AW];
  logic [ACC_W-1:0] acc_mem [2**ACC_AW];

  logic [CLEN_W-1:0] corr_length;
  logic [LAG_W-1:0]  ring_head;
  logic [FILL_W-1:0] fill_count;
  logic [TICK_W-1:0] accumulated_ticks;
  logic [ACC_AW-1:0] clr_addr;
  in_item_t          item;
  logic              ready_q;
  logic [CLEN_W-1:0] issue_lag;
  pos_t              hist_q;
  logic              hrd_v;
  logic [LAG_W-1:0]  hrd_lag, p1_lag, p2_lag;
  logic              p1_v;
  logic              dv;
  logic [DSUM_W-1:0] dsum;
  logic [ACC_W-1:0]  acc_q;
  logic [ACC_W-1:0]  fwd_val;
  logic [ACC_W:0]    acc_sum;
  logic [ACC_W-1:0]  acc_new;
  logic              cur_ready;
  logic [CLEN_W-1:0] cfg_sat;
  logic [LAG_W-1:0]  acc_rd_lag;

  assign cur_ready = ({1'b0, fill_count} + 7'd1) >= {1'b0, corr_length};
  assign in_ch.ready = (state == S_IDLE);
  assign cfg.ready = 1'b1;
  assign cfg_sat = (cfg.data < CLEN_W'(2)) ? CLEN_W'(2)
                 : (cfg.data > CLEN_W'(LAG_DEPTH)) ? CLEN_W'(LAG_DEPTH) : cfg.data;

  // history read at slot head-lag for the lag being issued
  always_ff @(posedge clk) begin
    hist_q <= hist_mem[{item.particle_index, ring_head - issue_lag[LAG_W-1:0]}];
    if (state == S_IDLE && in_ch.valid && in_ch.data.mode == MODE_SAMPLE)
      hist_mem[{in_ch.data.particle_index, ring_head}] <=
        '{x: in_ch.data.pos_x, y: in_ch.data.pos_y, z: in_ch.data.pos_z};
  end

  mlc_dist u_dist (
    .clk(clk), .rst(rst), .in_valid(hrd_v),
    .cur('{x: item.pos_x, y: item.pos_y, z: item.pos_z}),
    .old(hist_q), .out_valid(dv), .dsum(dsum)
  );

  // accumulator read-ahead: read the entry of the lag that arrives next
  assign acc_rd_lag = (state == S_READ) ? item.read_lag : p1_lag;
  always_ff @(posedge clk) begin
    acc_q <= acc_mem[{item.species_index, acc_rd_lag}];
    if (state == S_CLEAR) acc_mem[clr_addr] <= '0;
    else if (dv) acc_mem[{item.species_index, p2_lag}] <= acc_new;
  end

  // lags are distinct per cycle, so forwarding only matters across items
  assign fwd_val = acc_q;
  assign acc_sum = {1'b0, fwd_val} + (ACC_W+1)'(dsum);
  assign acc_new = acc_sum[ACC_W] ? '1 : acc_sum[ACC_W-1:0];

  // control and pipeline tags
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr_addr <= '0;
      corr_length <= CORR_LENGTH_RESET;
      ring_head <= '0;
      fill_count <= '0;
      accumulated_ticks <= '0;
      out_ch.valid <= 1'b0;
      hrd_v <= 1'b0;
      p1_v <= 1'b0;
      issue_lag <= '0;
    end else begin
      if (cfg.valid) corr_length <= cfg_sat;
      hrd_v <= (state == S_WALK);
      hrd_lag <= issue_lag[LAG_W-1:0];
      p1_lag <= hrd_lag;
      p2_lag <= p1_lag;
      p1_v <= hrd_v;
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == '1) state <= S_IDLE;
        end
        S_IDLE: if (in_ch.valid) begin
          item <= in_ch.data;
          ready_q <= cur_ready;
          issue_lag <= CLEN_W'(1);
          if (in_ch.data.mode == MODE_READ) state <= S_READ;
          else if ({1'b0, in_ch.data.particle_index} < 9'(PARTICLE_COUNT)
                   && cur_ready && {1'b0, in_ch.data.species_index} < 4'(SPECIES_COUNT))
            state <= S_WALK;
          else state <= S_DRAIN;
        end
        S_READ: state <= S_DRAIN;
        S_WALK: begin
          issue_lag <= issue_lag + 1'b1;
          if (issue_lag + 1'b1 >= corr_length) state <= S_DRAIN;
        end
        S_DRAIN: if (!hrd_v && !p1_v && !dv) begin
          out_ch.data.sum_value <= (item.mode == MODE_READ) ? acc_q : '0;
          out_ch.data.history_ready <= ready_q;
          out_ch.data.ticks_taken <= accumulated_ticks;
          if (item.mode == MODE_SAMPLE && item.last_of_tick) begin
            ring_head <= ring_head + 1'b1;
            if (fill_count != FILL_MAX) fill_count <= fill_count + 1'b1;
            if (ready_q && accumulated_ticks != '1) begin
              accumulated_ticks <= accumulated_ticks + 1'b1;
              out_ch.data.ticks_taken <= accumulated_ticks + 1'b1;
            end
          end
          out_ch.valid <= 1'b1;
          state <= S_OUT;
        end
        S_OUT: if (out_ch.ready) begin
          out_ch.valid <= 1'b0;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // the distance pipe is empty whenever an item is taken
  a_pipe_empty: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> (!hrd_v && !dv)) else $error("pipe busy at idle");
  // writebacks only happen while walking or draining
  a_wb_state: assert property (@(posedge clk) disable iff (rst)
    dv |-> (state == S_WALK || state == S_DRAIN)) else $error("stray writeback");
  // result appears only from the output state
  a_out_state: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> state == S_OUT) else $error("output outside S_OUT");
  // lag walk stays inside corr_length
  a_lag_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK) |-> (issue_lag < corr_length)) else $error("lag overrun");
endmodule

// File: sv/mlc_dist.sv
`timescale 1ns / 1ps
// Squared displacement unit: two register stages, three 25x25 squares.
// Depends on mlc_pkg.
module mlc_dist import mlc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  pos_t              cur,
  input  pos_t              old,
  output logic              out_valid,
  output logic [DSUM_W-1:0] dsum
);
  logic [DIFF_W-1:0] ax, ay, az;
  logic              v1;
  logic [SQ_W-1:0]   sx, sy, sz;

  function automatic logic [DIFF_W-1:0] absdiff(logic signed [COORD_BITS-1:0] a,
                                                logic signed [COORD_BITS-1:0] b);
    logic signed [DIFF_W-1:0] d;
    d = DIFF_W'(a) - DIFF_W'(b);
    return d[DIFF_W-1] ? DIFF_W'(-d) : DIFF_W'(d);
  endfunction

  // stage 1: absolute differences
  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else v1 <= in_valid;
    ax <= absdiff(cur.x, old.x);
    ay <= absdiff(cur.y, old.y);
    az <= absdiff(cur.z, old.z);
  end

  // stage 2: squares; sum is left combinational for the adder stage
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else out_valid <= v1;
    sx <= SQ_W'(ax * ax);
    sy <= SQ_W'(ay * ay);
    sz <= SQ_W'(az * az);
  end

  assign dsum = DSUM_W'(sx) + DSUM_W'(sy) + DSUM_W'(sz);
endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps
// Self-checking regression for msd_lag_correlator: ticks of position samples
// and accumulator reads, with a predictor of the lag sums kept in step.
// Depends on mlc_pkg, the mlc_if interfaces and the msd_lag_correlator RTL.
module testbench;
  import mlc_pkg::*;

  localparam int CORE_PARTS = 4;

  logic clk;
  logic rst;

  mlc_in_if  in_ch();
  mlc_out_if out_ch();
  mlc_cfg_if cfg();

  msd_lag_correlator u_top (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg    (cfg)
  );

  // Clock, 2 ns period
  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  // Predictor state
  int               hist_x [PARTICLE_COUNT][LAG_DEPTH];
  int               hist_y [PARTICLE_COUNT][LAG_DEPTH];
  int               hist_z [PARTICLE_COUNT][LAG_DEPTH];
  bit               slot_written [PARTICLE_COUNT][LAG_DEPTH];
  longint unsigned  lag_sum [SPECIES_COUNT][LAG_DEPTH];
  int unsigned      head_slot;
  int unsigned      ticks_filled;
  int unsigned      ticks_summed;
  int unsigned      lag_count;

  out_item_t expected_results[$];
  int        mismatches;
  int        burst_left;
  int        hold_cycles;
  bit        stall_on;
  logic [15:0] stall_mask;

  function automatic longint unsigned sq_disp(int a, int b);
    longint d;
    d = longint'(a) - longint'(b);
    if (d < 0) d = -d;
    return longint'(unsigned'(d)) * d;
  endfunction

  function automatic bit tick_sums();
    return ticks_filled + 1 >= lag_count;
  endfunction

  // A ready sample reads lags back to corr_length-1; all must hold data.
  function automatic bit history_complete(int p);
    if (!tick_sums()) return 1'b1;
    for (int k = 1; k < lag_count; k++)
      if (!slot_written[p][(head_slot + LAG_DEPTH - k) % LAG_DEPTH]) return 1'b0;
    return 1'b1;
  endfunction

  // Advance the predictor by one accepted item and return its result.
  function automatic out_item_t predict_step(in_item_t it);
    out_item_t r;
    bit ready;
    int p;
    int s;
    int slot;
    longint unsigned d;
    longint unsigned acc;
    ready = tick_sums();
    r.sum_value = '0;
    p = it.particle_index;
    s = it.species_index;
    if (it.mode == MODE_READ) begin
      r.sum_value = lag_sum[s][it.read_lag];
    end else begin
      hist_x[p][head_slot] = it.pos_x;
      hist_y[p][head_slot] = it.pos_y;
      hist_z[p][head_slot] = it.pos_z;
      slot_written[p][head_slot] = 1'b1;
      if (ready) begin
        for (int k = 1; k < lag_count; k++) begin
          slot = (head_slot + LAG_DEPTH - k) % LAG_DEPTH;
          d = sq_disp(hist_x[p][slot], it.pos_x) + sq_disp(hist_y[p][slot], it.pos_y)
            + sq_disp(hist_z[p][slot], it.pos_z);
          acc = lag_sum[s][k] + d;
          lag_sum[s][k] = (acc < lag_sum[s][k]) ? '1 : acc;
        end
      end
      if (it.last_of_tick) begin
        head_slot = (head_slot + 1) % LAG_DEPTH;
        if (ticks_filled < FILL_MAX) ticks_filled++;
        if (ready && ticks_summed != 32'hFFFF_FFFF) ticks_summed++;
      end
    end
    r.ticks_taken = ticks_summed;
    r.history_ready = ready;
    return r;
  endfunction

  function automatic logic [COORD_BITS-1:0] rand_coord();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 1) ? {1'b0, {(COORD_BITS-1){1'b1}}}
                                     : {1'b1, {(COORD_BITS-1){1'b0}}};
      1: return COORD_BITS'($signed($urandom_range(0, 2000)) - 1000);
      default: return COORD_BITS'($urandom);
    endcase
  endfunction

  function automatic in_item_t sample_item(int p, int s, bit last);
    in_item_t it;
    it.mode = MODE_SAMPLE;
    it.particle_index = PART_W'(p);
    it.species_index = SPEC_W'(s);
    it.pos_x = rand_coord();
    it.pos_y = rand_coord();
    it.pos_z = rand_coord();
    it.read_lag = LAG_W'($urandom);
    it.last_of_tick = last;
    return it;
  endfunction

  function automatic in_item_t read_item(int s, int lag);
    in_item_t it;
    it = sample_item($urandom_range(0, 255), s, $urandom_range(0, 1));
    it.mode = MODE_READ;
    it.read_lag = LAG_W'(lag);
    return it;
  endfunction

  // Send one item with burst gaps; predict on acceptance.
  task automatic send_item(in_item_t it);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
    end
    burst_left--;
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= it;
    do @(posedge clk); while (!in_ch.ready);
    expected_results.push_back(predict_step(it));
  endtask

  task automatic input_idle();
    @(negedge clk);
    in_ch.valid <= 1'b0;
  endtask

  // Wait for every expected result to be received, then idle before returning.
  task automatic drain();
    input_idle();
    wait (expected_results.size() == 0);
    repeat (50) @(posedge clk);
  endtask

  task automatic set_corr_length(logic [CLEN_W-1:0] v);
    drain();
    @(negedge clk);
    cfg.valid <= 1'b1;
    cfg.data <= v;
    do @(posedge clk); while (!cfg.ready);
    @(negedge clk);
    cfg.valid <= 1'b0;
    lag_count = v < 2 ? 2 : (v > LAG_DEPTH ? LAG_DEPTH : v);
  endtask

  // One tick: core particles, random extras and reads, then a closing sample.
  task automatic run_tick(int extras);
    int p;
    for (int i = 0; i < CORE_PARTS; i++)
      if (history_complete(i)) send_item(sample_item(i, $urandom_range(0, 7), 1'b0));
    for (int i = 0; i < extras; i++) begin
      p = $urandom_range(0, 1) ? $urandom_range(0, 15) : $urandom_range(0, 255);
      if ($urandom_range(0, 5) == 0 || !history_complete(p))
        send_item(read_item($urandom_range(0, 7), $urandom_range(0, 31)));
      else
        send_item(sample_item(p, $urandom_range(0, 7), 1'b0));
    end
    send_item(sample_item(0, $urandom_range(0, 7), 1'b1));
  endtask

  task automatic run_ticks(int n);
    for (int t = 0; t < n; t++) run_tick($urandom_range(0, 8));
  endtask

  // Extremes of fields before history fills; reads of lag 0 and 31
  task automatic test_directed();
    in_item_t it;
    it = sample_item(255, 7, 1'b0);
    it.pos_x = {1'b0, {(COORD_BITS-1){1'b1}}};
    it.pos_y = {1'b1, {(COORD_BITS-1){1'b0}}};
    it.pos_z = '1;
    send_item(it);
    it = sample_item(0, 0, 1'b0);
    it.pos_x = {1'b1, {(COORD_BITS-1){1'b0}}};
    it.pos_y = {1'b0, {(COORD_BITS-1){1'b1}}};
    it.pos_z = '0;
    send_item(it);
    send_item(read_item(7, 31));
    send_item(read_item(0, 0));
    for (int i = 1; i < CORE_PARTS; i++) send_item(sample_item(i, i, 1'b0));
    send_item(sample_item(128, 5, 1'b1));
    run_ticks(34);
  endtask

  // Alternate extreme coordinates so lag sums take the largest steps
  task automatic test_extremes();
    in_item_t it;
    for (int t = 0; t < 4; t++) begin
      for (int i = 0; i < CORE_PARTS; i++) begin
        it = sample_item(i, 7 * (t % 2), i == CORE_PARTS - 1);
        it.pos_x = t % 2 ? {1'b0, {(COORD_BITS-1){1'b1}}} : {1'b1, {(COORD_BITS-1){1'b0}}};
        it.pos_y = it.pos_x;
        it.pos_z = it.pos_x;
        send_item(it);
      end
    end
    for (int l = 0; l < LAG_DEPTH; l++) send_item(read_item(7, l));
  endtask

  // Hold off the output while items keep coming, then pause for a full drain
  task automatic test_backpressure();
    hold_cycles = 400;
    run_ticks(2);
    drain();
    run_ticks(2);
  endtask

  task automatic test_corr_lengths();
    set_corr_length(CLEN_W'(32));
    run_ticks(20);
    set_corr_length(CLEN_W'(0));
    run_ticks(15);
    set_corr_length(CLEN_W'(63));
    run_ticks(15);
    set_corr_length(CLEN_W'(1));
    run_ticks(10);
    set_corr_length(CLEN_W'(2));
    run_ticks(10);
    set_corr_length(CLEN_W'(7));
    run_ticks(15);
    set_corr_length(CLEN_W'(20));
    run_ticks(12);
    for (int l = 0; l < LAG_DEPTH; l++) send_item(read_item($urandom_range(0, 7), l));
  endtask

  // Receiver stalls on a shifting pattern, with long holds on request
  always @(negedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ch.ready <= 1'b0;
    end else begin
      if ($urandom_range(0, 63) == 0) begin
        stall_on <= 1'($urandom_range(0, 1));
        stall_mask <= 16'($urandom);
      end else begin
        stall_mask <= {stall_mask[14:0], stall_mask[15]};
      end
      out_ch.ready <= !stall_on || stall_mask[0];
    end
  end

  // Check each result against the oldest prediction
  always @(posedge clk) begin
    out_item_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", out_ch.data);
      end else begin
        want = expected_results.pop_front();
        if (out_ch.data.sum_value !== want.sum_value
            || out_ch.data.ticks_taken !== want.ticks_taken
            || out_ch.data.history_ready !== want.history_ready) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected sum %0d ticks %0d ready %0d, got %0d %0d %0d",
                     want.sum_value, want.ticks_taken, want.history_ready,
                     out_ch.data.sum_value, out_ch.data.ticks_taken,
                     out_ch.data.history_ready);
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("msd_lag_correlator regression: fail");
    $finish;
  end

  initial begin
    rst = 1'b1;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    cfg.valid = 1'b0;
    cfg.data = '0;
    stall_on = 1'b0;
    stall_mask = 16'hFFFF;
    hold_cycles = 0;
    burst_left = 0;
    mismatches = 0;
    head_slot = 0;
    ticks_filled = 0;
    ticks_summed = 0;
    lag_count = CORR_LENGTH_RESET;
    foreach (lag_sum[s, l]) lag_sum[s][l] = 0;
    foreach (slot_written[p, k]) slot_written[p][k] = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed();
    test_extremes();
    test_backpressure();
    test_corr_lengths();
    drain();
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("msd_lag_correlator regression: pass");
    end else begin
      $display("msd_lag_correlator regression: fail");
    end
    $finish;
  end
endmodule
